>>> hw/rtl/tps_pkg.sv
// Shared constants, types and the class bonus table of the target priority selector.
package tps_pkg;

  localparam int MAX_TARGETS = 16;
  localparam int COORD_BITS  = 11;

  localparam int AREA_W  = 22;
  localparam int CLASS_W = 4;
  localparam int INDEX_W = 4;
  localparam int CNT_W   = $clog2(MAX_TARGETS + 1);

  // Squared distance, the radicand (sixteen times the squared distance,
  // padded to an even width) and the root with two fraction bits.
  localparam int SQ_W   = 2 * COORD_BITS + 1;
  localparam int ROOT_W = (SQ_W + 4 + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  localparam int BONUS_W     = 13;
  localparam int MATCH_BONUS = 100000;
  localparam int BASE_W      = AREA_W + 1;
  localparam int SCORE_W     = 26;

  // Configuration port.
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_WANTED_CLASS = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_SCORE,
    ST_EMIT
  } state_t;

  function automatic logic [BONUS_W-1:0] class_bonus(input logic [CLASS_W-1:0] cls);
    logic [BONUS_W-1:0] b;
    case (cls)
      4'd1:    b = BONUS_W'(4000);
      4'd2:    b = BONUS_W'(3000);
      4'd3:    b = BONUS_W'(6000);
      4'd4:    b = BONUS_W'(5000);
      4'd5:    b = BONUS_W'(2000);
      4'd6:    b = BONUS_W'(1000);
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/tps_if.sv
// Valid/ready channel interfaces for target beats and pick beats.
interface tps_in_if
  import tps_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic                  present;
  logic [AREA_W-1:0]     target_area;
  logic [CLASS_W-1:0]    class_number;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic                  frame_last;

  modport source (
    output valid, present, target_area, class_number, center_x, center_y, frame_last,
    input  ready
  );
  modport sink (
    input  valid, present, target_area, class_number, center_x, center_y, frame_last,
    output ready
  );
endinterface

interface tps_out_if
  import tps_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [INDEX_W-1:0]    pick_index;
  logic [CLASS_W-1:0]    pick_class;
  logic [COORD_BITS-1:0] pick_x;
  logic [COORD_BITS-1:0] pick_y;
  logic [AREA_W-1:0]     pick_area;

  modport source (
    output valid, found, pick_index, pick_class, pick_x, pick_y, pick_area,
    input  ready
  );
  modport sink (
    input  valid, found, pick_index, pick_class, pick_x, pick_y, pick_area,
    output ready
  );
endinterface

>>> hw/rtl/target_priority_selector.sv
// Top level of the target priority selector: sequencer, scoring and pick register.
//
// Usage. Targets of one frame arrive on the input channel, one beat per
// target; frame_last marks the final beat of the frame, and a beat with
// present low stands for a frame with no targets and closes it at once.
// For each frame exactly one pick beat leaves on the output channel. The
// wanted class is written through the APB-style port while the block is idle.
//
// Sequence. A beat is taken in the idle state. When the previous frame's pick
// had a nonzero class, the squared distance to it is formed on one shared
// multiplier, dx squared and then dy squared added, and its root is extracted
// one bit per cycle, after which the finished root is handed over and the
// beat is scored. Without a previous class the squared distance and root
// are skipped and the beat goes straight to scoring. Beats beyond the
// sixteenth of a frame are taken but not scored. A closing beat then
// passes the emit state, which loads the pick register once it is free.
//
// Reset clears the wanted class, the frame in progress and the remembered
// pick, and empties the pick register. The pick register parts the two
// sides: a new frame is taken while a pick waits, and the block only halts
// when a second pick is ready before the first has been taken.
module target_priority_selector
  import tps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  tps_in_if.sink             in_ch,
  tps_out_if.source          out_ch
);

  state_t state;
  state_t state_next;

  logic [CLASS_W-1:0] wanted_class;

  // Frame in progress.
  logic                       have_best;
  logic signed [SCORE_W-1:0]  best_score;
  logic [INDEX_W-1:0]         best_index;
  logic [CLASS_W-1:0]         best_class;
  logic [COORD_BITS-1:0]      best_x;
  logic [COORD_BITS-1:0]      best_y;
  logic [AREA_W-1:0]          best_area;
  logic [CNT_W-1:0]           item_counter;

  // Pick of the previous frame.
  logic [CLASS_W-1:0]    prev_class;
  logic [COORD_BITS-1:0] prev_x;
  logic [COORD_BITS-1:0] prev_y;

  // Target beat being worked on.
  logic                  cur_empty;
  logic                  cur_last;
  logic [AREA_W-1:0]     cur_area;
  logic [CLASS_W-1:0]    cur_class;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [COORD_BITS-1:0] dx_abs;
  logic [COORD_BITS-1:0] dy_abs;
  logic [COORD_BITS-1:0] dx_abs_next;
  logic [COORD_BITS-1:0] dy_abs_next;
  logic [SQ_W-1:0]       sq_acc;

  // Sequencer outputs.
  logic in_accept;
  logic sq_first;
  logic sq_second;
  logic score_en;
  logic emit_load;
  logic out_free;

  // Datapath.
  logic [COORD_BITS-1:0]     mul_op;
  logic [2*COORD_BITS-1:0]   prod;
  logic [SQ_W-1:0]           sq_sum;
  logic [RAD_W-1:0]          radicand;
  logic                      root_done;
  logic [ROOT_W-1:0]         root;
  logic [BASE_W-1:0]         base;
  logic signed [SCORE_W-1:0] score;
  logic [ROOT_W:0]           penalty;
  logic                      take;
  logic                      counter_full;

  tps_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .wanted_class (wanted_class)
  );

  // Squared distance: dx squared in the SQX state, dy squared added in SQY,
  // and the sum goes straight into the root unit scaled by sixteen.
  assign mul_op   = sq_first ? dx_abs : dy_abs;
  assign prod     = mul_op * mul_op;
  assign sq_sum   = sq_acc + SQ_W'(prod);
  assign radicand = RAD_W'({sq_sum, 4'b0000});

  tps_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_second),
    .radicand (radicand),
    .done     (root_done),
    .root     (root)
  );

  assign dx_abs_next = (in_ch.center_x >= prev_x) ? (in_ch.center_x - prev_x)
                                                  : (prev_x - in_ch.center_x);
  assign dy_abs_next = (in_ch.center_y >= prev_y) ? (in_ch.center_y - prev_y)
                                                  : (prev_y - in_ch.center_y);

  assign counter_full = (item_counter >= CNT_W'(MAX_TARGETS));

  // Score in quarter units: four times area and bonuses, less twice the
  // distance root, which already carries two fraction bits.
  always_comb begin
    base = BASE_W'(cur_area);
    if (wanted_class == '0) begin
      base = base + BASE_W'(class_bonus(cur_class));
    end
    if (cur_class == wanted_class) begin
      base = base + BASE_W'(MATCH_BONUS);
    end
    if (prev_class != '0) begin
      penalty = {root, 1'b0};
    end else begin
      penalty = '0;
    end
    score = signed'(SCORE_W'({base, 2'b00})) - signed'(SCORE_W'(penalty));
    take  = !have_best || (score > best_score);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (!in_ch.present) begin
            state_next = ST_EMIT;
          end else if (counter_full) begin
            state_next = in_ch.frame_last ? ST_EMIT : ST_IDLE;
          end else if (prev_class != '0) begin
            state_next = ST_SQX;
          end else begin
            state_next = ST_SCORE;
          end
        end
      end
      ST_SQX:   state_next = ST_SQY;
      ST_SQY:   state_next = ST_ROOT;
      ST_ROOT: begin
        if (root_done) begin
          state_next = ST_SCORE;
        end
      end
      ST_SCORE: state_next = cur_last ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    sq_first    = 1'b0;
    sq_second   = 1'b0;
    score_en    = 1'b0;
    emit_load   = 1'b0;
    case (state)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_SQX:   sq_first    = 1'b1;
      ST_SQY:   sq_second   = 1'b1;
      ST_ROOT:  ;
      ST_SCORE: score_en    = 1'b1;
      ST_EMIT:  emit_load   = out_free;
      default:  ;
    endcase
  end

  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free  = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Beat capture and squared distance accumulation.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_empty <= !in_ch.present;
      cur_last  <= in_ch.frame_last;
      cur_area  <= in_ch.target_area;
      cur_class <= in_ch.class_number;
      cur_x     <= in_ch.center_x;
      cur_y     <= in_ch.center_y;
      dx_abs    <= dx_abs_next;
      dy_abs    <= dy_abs_next;
    end
    if (sq_first) begin
      sq_acc <= SQ_W'(prod);
    end
  end

  // Best so far, item count and the remembered pick.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_best    <= 1'b0;
      best_score   <= '0;
      best_index   <= '0;
      best_class   <= '0;
      best_x       <= '0;
      best_y       <= '0;
      best_area    <= '0;
      item_counter <= '0;
      prev_class   <= '0;
      prev_x       <= '0;
      prev_y       <= '0;
    end else if (emit_load) begin
      if (cur_empty) begin
        prev_class <= '0;
        prev_x     <= '0;
        prev_y     <= '0;
      end else begin
        prev_class <= best_class;
        prev_x     <= best_x;
        prev_y     <= best_y;
      end
      have_best    <= 1'b0;
      best_score   <= '0;
      best_index   <= '0;
      best_class   <= '0;
      best_x       <= '0;
      best_y       <= '0;
      best_area    <= '0;
      item_counter <= '0;
    end else if (score_en) begin
      if (take) begin
        have_best  <= 1'b1;
        best_score <= score;
        best_index <= INDEX_W'(item_counter);
        best_class <= cur_class;
        best_x     <= cur_x;
        best_y     <= cur_y;
        best_area  <= cur_area;
      end
      item_counter <= item_counter + 1'b1;
    end
  end

  // Pick register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (emit_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      if (cur_empty) begin
        out_ch.found      <= 1'b0;
        out_ch.pick_index <= '0;
        out_ch.pick_class <= '0;
        out_ch.pick_x     <= '0;
        out_ch.pick_y     <= '0;
        out_ch.pick_area  <= '0;
      end else begin
        out_ch.found      <= 1'b1;
        out_ch.pick_index <= best_index;
        out_ch.pick_class <= best_class;
        out_ch.pick_x     <= best_x;
        out_ch.pick_y     <= best_y;
        out_ch.pick_area  <= best_area;
      end
    end
  end

endmodule

>>> hw/rtl/tps_regs.sv
// APB-style configuration register holding the wanted class.
module tps_regs
  import tps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  output logic [CLASS_W-1:0]  wanted_class
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_class <= '0;
    end else if (wr_en && (reg_idx == REG_WANTED_CLASS)) begin
      wanted_class <= pwdata[CLASS_W-1:0];
    end
  end

  always_comb begin
    if (reg_idx == REG_WANTED_CLASS) begin
      prdata = PDATA_W'(wanted_class);
    end else begin
      prdata = '0;
    end
  end

endmodule

>>> hw/rtl/tps_isqrt.sv
// Digit-serial integer square root: two radicand bits in, one root bit out per cycle.
module tps_isqrt
  import tps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]  rad_sr;
  logic [ROOT_W:0]   rem;
  logic [ROOT_W:0]   rem_next;
  logic [ROOT_W-1:0] root_next;
  logic [STEP_W-1:0] steps;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] diff;

  // Bring down the next radicand digit and try the next root bit.
  always_comb begin
    rem_sh = {rem, rad_sr[RAD_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    diff   = rem_sh - trial;
    if (rem_sh >= trial) begin
      rem_next  = diff[ROOT_W:0];
      root_next = {root[ROOT_W-2:0], 1'b1};
    end else begin
      rem_next  = rem_sh[ROOT_W:0];
      root_next = {root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= STEP_W'(ROOT_W);
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sr <= radicand;
      rem    <= '0;
      root   <= '0;
    end else if (steps != '0) begin
      rad_sr <= {rad_sr[RAD_W-3:0], 2'b00};
      rem    <= rem_next;
      root   <= root_next;
    end
  end

endmodule

>>> bench/target_priority_selector_tb.sv
// Self-checking bench for the target priority selector: directed frames, then random frames.
`timescale 1ns / 100ps

module target_priority_selector_tb;
  import tps_pkg::*;

  // Clock and run control.
  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 2;
  localparam int PHASES          = 6;
  localparam int BEATS_PER_PHASE = 258;
  // Ample time for a scored target beat and a closing beat to pass, so the
  // block comes to rest once the last pick is in.
  localparam int SETTLE_CYCLES   = 40;
  localparam int CYCLE_LIMIT     = 1_000_000;

  localparam logic [AREA_W-1:0]     AREA_MAX  = '1;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

  // The only other index the address decoder can see; writes to it are dropped.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;

  // Bonus in whole pixels that a class earns while the wanted class is zero.
  localparam int CLASS_BONUS_TABLE [16] = '{0, 4000, 3000, 6000, 5000, 2000, 1000, 0,
                                            0, 0, 0, 0, 0, 0, 0, 0};

  // Wanted class for each random phase; the last phase draws its own value.
  localparam logic [CLASS_W-1:0] PHASE_WANTED [PHASES] = '{4'd0, 4'd15, 4'd3, 4'd0, 4'd9, 4'd0};

  typedef struct packed {
    logic                  present;
    logic [AREA_W-1:0]     area;
    logic [CLASS_W-1:0]    cls;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } target_beat_t;

  typedef struct packed {
    logic                  found;
    logic [INDEX_W-1:0]    index;
    logic [CLASS_W-1:0]    cls;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [AREA_W-1:0]     area;
  } pick_t;

  // One row of the directed table: the beat is sent reps times, frame_last only
  // on the final copy. Where typed is set, the pick written in the row is the
  // one expected; otherwise the pick comes from the predictor.
  typedef struct packed {
    logic [4:0]   reps;
    target_beat_t beat;
    logic         typed;
    pick_t        pick;
  } directed_row_t;

  localparam pick_t NO_PICK = '0;
  localparam int DIRECTED_ROWS = 13;

  // The directed part starts straight after reset, so the wanted class is zero
  // and there is no remembered pick.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Largest area, highest class and far corner in a frame of one.
    '{5'd1, '{1'b1, AREA_MAX, 4'd15, COORD_MAX, COORD_MAX, 1'b1},
      1'b1, '{1'b1, 4'd0, 4'd15, COORD_MAX, COORD_MAX, AREA_MAX}},
    // Empty frame with every other field high and frame_last low: it still closes.
    '{5'd1, '{1'b0, AREA_MAX, 4'd15, COORD_MAX, COORD_MAX, 1'b0}, 1'b1, NO_PICK},
    // Empty frame with frame_last high.
    '{5'd1, '{1'b0, 22'd0, 4'd0, 11'd0, 11'd0, 1'b1}, 1'b1, NO_PICK},
    // Unknown class with wanted class zero earns the match bonus and beats a
    // larger class-three target.
    '{5'd1, '{1'b1, 22'd0, 4'd0, 11'd0, 11'd0, 1'b0}, 1'b0, NO_PICK},
    '{5'd1, '{1'b1, 22'd90000, 4'd3, 11'd5, 11'd5, 1'b1}, 1'b0, NO_PICK},
    // The previous pick had class zero, so distance does not count: equal
    // scores, and the first of the two wins.
    '{5'd1, '{1'b1, 22'd500, 4'd8, COORD_MAX, COORD_MAX, 1'b0}, 1'b0, NO_PICK},
    '{5'd1, '{1'b1, 22'd500, 4'd8, 11'd0, 11'd0, 1'b1}, 1'b0, NO_PICK},
    // Now the previous pick sits in the far corner: the nearer twin wins.
    '{5'd1, '{1'b1, 22'd1000, 4'd1, 11'd0, 11'd0, 1'b0}, 1'b0, NO_PICK},
    '{5'd1, '{1'b1, 22'd1000, 4'd1, COORD_MAX, COORD_MAX, 1'b1}, 1'b0, NO_PICK},
    // Largest possible distance penalty on a tiny target.
    '{5'd1, '{1'b1, 22'd7, 4'd2, 11'd0, 11'd0, 1'b1}, 1'b0, NO_PICK},
    // Empty frame clears the remembered pick.
    '{5'd1, '{1'b0, 22'h155555, 4'd10, 11'h555, 11'h2AA, 1'b1}, 1'b1, NO_PICK},
    // Sixteen equal targets, then a huge one past the limit that must be ignored.
    '{5'd16, '{1'b1, 22'd10, 4'd9, 11'd3, 11'd4, 1'b0}, 1'b0, NO_PICK},
    '{5'd1, '{1'b1, AREA_MAX, 4'd9, 11'd0, 11'd0, 1'b1},
      1'b1, '{1'b1, 4'd0, 4'd9, 11'd3, 11'd4, 22'd10}}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  tps_in_if  target_ch ();
  tps_out_if pick_ch ();

  target_priority_selector i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (target_ch),
    .out_ch  (pick_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Predictor state: the wanted class, the best target of the frame so far
  // with its score in quarter pixels, and the pick remembered from the last
  // frame that closed.
  logic [CLASS_W-1:0]    wanted_class_q;
  pick_t                 frame_best;
  longint                best_score;
  bit                    have_best;
  int                    beats_in_frame;
  logic [CLASS_W-1:0]    last_pick_class;
  logic [COORD_BITS-1:0] last_pick_x;
  logic [COORD_BITS-1:0] last_pick_y;

  pick_t       pending_picks [$];
  int          errors = 0;
  int unsigned cycle_count = 0;
  bit          no_idling = 1'b0;
  bit          source_quiet = 1'b0;

  function automatic void clear_frame_best();
    frame_best     = '0;
    best_score     = 0;
    have_best      = 1'b0;
    beats_in_frame = 0;
  endfunction

  // Largest r with r*r <= v; the radicand stays below 2^28.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = 15; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Score in quarter pixels: four times area plus bonuses, less twice the
  // distance to the last pick held with two fraction bits.
  function automatic longint quarter_score(input target_beat_t b);
    longint          s;
    longint          dx;
    longint          dy;
    longint unsigned sq;
    s = longint'(b.area);
    if (wanted_class_q == '0) s = s + CLASS_BONUS_TABLE[b.cls];
    if (b.cls == wanted_class_q) s = s + MATCH_BONUS;
    s = s * 4;
    if (last_pick_class != '0) begin
      dx = longint'(b.x) - longint'(last_pick_x);
      dy = longint'(b.y) - longint'(last_pick_y);
      sq = dx * dx + dy * dy;
      s = s - 2 * longint'(floor_root(sq * 16));
    end
    return s;
  endfunction

  // Takes one accepted beat; returns 1 with the pick when the beat closes a frame.
  function automatic bit predict_pick(input target_beat_t b, output pick_t p);
    longint s;
    p = '0;
    if (!b.present) begin
      clear_frame_best();
      last_pick_class = '0;
      last_pick_x     = '0;
      last_pick_y     = '0;
      return 1'b1;
    end
    if (beats_in_frame < MAX_TARGETS) begin
      s = quarter_score(b);
      if (!have_best || s > best_score) begin
        have_best        = 1'b1;
        best_score       = s;
        frame_best.index = INDEX_W'(beats_in_frame);
        frame_best.cls   = b.cls;
        frame_best.x     = b.x;
        frame_best.y     = b.y;
        frame_best.area  = b.area;
      end
      beats_in_frame++;
    end
    if (!b.last) return 1'b0;
    p               = frame_best;
    p.found         = 1'b1;
    last_pick_class = frame_best.cls;
    last_pick_x     = frame_best.x;
    last_pick_y     = frame_best.y;
    clear_frame_best();
    return 1'b1;
  endfunction

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: pick %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // Sends one beat, holding valid until the block takes it, and records what
  // the beat should produce. A random pause may come first, unless the source
  // is in a quiet stretch or the run is in its final, idle-free phase.
  task automatic send_beat(input target_beat_t b, input bit use_typed, input pick_t typed_pick);
    pick_t p;
    if (!no_idling && !source_quiet && $urandom_range(0, 4) == 0) begin
      target_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    target_ch.valid        <= 1'b1;
    target_ch.present      <= b.present;
    target_ch.target_area  <= b.area;
    target_ch.class_number <= b.cls;
    target_ch.center_x     <= b.x;
    target_ch.center_y     <= b.y;
    target_ch.frame_last   <= b.last;
    @(posedge clk);
    while (!target_ch.ready) @(posedge clk);
    if (predict_pick(b, p)) pending_picks.push_back(use_typed ? typed_pick : p);
  endtask

  // Stops the source and waits until every pick has arrived and the block is at rest.
  task automatic drain_picks();
    target_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A write is a setup phase and then an access phase; the bus idles again
  // afterwards so that a second transfer can start cleanly.
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WANTED_CLASS) wanted_class_q = data[CLASS_W-1:0];
    @(posedge clk);
  endtask

  task automatic check_wanted_class_readback();
    logic [PDATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_WANTED_CLASS, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== PDATA_W'(wanted_class_q)) begin
      errors++;
      $display("%0t: wanted_class readback mismatch, expected %0d, actual %0h",
               $time, wanted_class_q, rd);
    end
    @(posedge clk);
  endtask

  // Random frames until about target_beats scored beats have gone in. Most
  // frames hold one to four targets; some run past the sixteen-target limit
  // and a few are empty. Areas and centres are often copied from the beat
  // before, classes often the wanted class, so ties and near-ties come up often.
  task automatic run_random_frames(input int target_beats);
    int           sent;
    int           frame_len;
    int           kind;
    target_beat_t b;
    target_beat_t prev_b;
    sent   = 0;
    prev_b = '0;
    while (sent < target_beats) begin
      if ($urandom_range(0, 15) == 0) source_quiet = !source_quiet;
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        // Empty frame: everything but present is arbitrary.
        b.present = 1'b0;
        b.area    = AREA_W'($urandom);
        b.cls     = CLASS_W'($urandom);
        b.x       = COORD_BITS'($urandom);
        b.y       = COORD_BITS'($urandom);
        b.last    = 1'($urandom);
        send_beat(b, 1'b0, NO_PICK);
        sent++;
      end else begin
        frame_len = (kind < 10) ? $urandom_range(MAX_TARGETS + 1, MAX_TARGETS + 4)
                                : $urandom_range(1, 4);
        for (int i = 0; i < frame_len; i++) begin
          b.present = 1'b1;
          case ($urandom_range(0, 5))
            0, 1:    b.area = AREA_W'($urandom_range(0, AREA_MAX));
            2:       b.area = AREA_W'($urandom_range(0, 8000));
            3:       b.area = $urandom_range(0, 1) ? AREA_MAX : '0;
            default: b.area = prev_b.area;
          endcase
          b.cls = ($urandom_range(0, 2) == 0) ? wanted_class_q : CLASS_W'($urandom_range(0, 15));
          case ($urandom_range(0, 3))
            0: begin
              b.x = prev_b.x;
              b.y = prev_b.y;
            end
            1: begin
              b.x = $urandom_range(0, 1) ? COORD_MAX : '0;
              b.y = $urandom_range(0, 1) ? COORD_MAX : '0;
            end
            default: begin
              b.x = COORD_BITS'($urandom);
              b.y = COORD_BITS'($urandom);
            end
          endcase
          // Now and then an exact twin of the previous target.
          if ($urandom_range(0, 9) == 0) b = prev_b;
          b.present = 1'b1;
          b.last    = (i == frame_len - 1);
          send_beat(b, 1'b0, NO_PICK);
          prev_b = b;
          if (i < MAX_TARGETS) sent++;
        end
      end
      // Occasionally hold the source back until every pick has been delivered.
      if ($urandom_range(0, 59) == 0) drain_picks();
    end
  endtask

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // The pick sink stalls in random bursts, with long stretches of full
  // readiness in between, and never stalls in the final phase.
  initial begin
    pick_ch.ready <= 1'b0;
    forever begin
      if (no_idling || $urandom_range(0, 2) == 0) begin
        pick_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        pick_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        pick_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Every pick beat is compared with the oldest outstanding expectation.
  always @(posedge clk) begin
    pick_t got;
    pick_t want;
    if (!rst && pick_ch.valid && pick_ch.ready) begin
      got = {pick_ch.found, pick_ch.pick_index, pick_ch.pick_class,
             pick_ch.pick_x, pick_ch.pick_y, pick_ch.pick_area};
      if (pending_picks.size() == 0) begin
        errors++;
        $display("%0t: pick beat with none outstanding, expected none, actual %0h",
                 $time, got);
      end else begin
        want = pending_picks.pop_front();
        compare_field("found", want.found, got.found);
        compare_field("pick_index", want.index, got.index);
        compare_field("pick_class", want.cls, got.cls);
        compare_field("pick_x", want.x, got.x);
        compare_field("pick_y", want.y, got.y);
        compare_field("pick_area", want.area, got.area);
      end
    end
  end

  initial begin
    directed_row_t      row;
    target_beat_t       b;
    logic [PDATA_W-1:0] wdata;

    // Every input is known from time zero.
    rst                    <= 1'b1;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    target_ch.valid        <= 1'b0;
    target_ch.present      <= 1'b0;
    target_ch.target_area  <= '0;
    target_ch.class_number <= '0;
    target_ch.center_x     <= '0;
    target_ch.center_y     <= '0;
    target_ch.frame_last   <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    wanted_class_q  = '0;
    last_pick_class = '0;
    last_pick_x     = '0;
    last_pick_y     = '0;
    clear_frame_best();
    @(posedge clk);

    // The register must read back its reset value before anything is written.
    check_wanted_class_readback();

    // Directed table, walked row by row.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = DIRECTED[r];
      for (int k = 0; k < row.reps; k++) begin
        b      = row.beat;
        b.last = row.beat.last && (k == row.reps - 1);
        send_beat(b, row.typed, row.pick);
      end
    end
    drain_picks();

    // Random phases, each under its own wanted class. The register is only
    // touched once the block has delivered every pick and come to rest. The
    // spare index is also written once, just before the wanted class.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain_picks();
        if (phase == 2) apb_write(REG_SPARE, $urandom);
        wdata = $urandom;
        wdata[CLASS_W-1:0] = (phase == PHASES - 1) ? CLASS_W'($urandom_range(1, 14))
                                                   : PHASE_WANTED[phase];
        apb_write(REG_WANTED_CLASS, wdata);
        check_wanted_class_readback();
      end
      no_idling = (phase == PHASES - 1);
      run_random_frames(BEATS_PER_PHASE);
    end

    drain_picks();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/tps_pkg.sv
hw/rtl/tps_if.sv
hw/rtl/tps_regs.sv
hw/rtl/tps_isqrt.sv
hw/rtl/target_priority_selector.sv
bench/target_priority_selector_tb.sv
